[sv/itwt_pkg.sv]
// itwt_pkg: shared widths, token codes and controller/datapath link types
// for integer_to_word_tokens. No dependencies.
package itwt_pkg;

  localparam int unsigned VALUE_W  = 31;
  localparam int unsigned CODE_W   = 5;
  localparam int unsigned DIGITS   = 10;
  localparam int unsigned BCD_W    = 4 * DIGITS;
  localparam int unsigned GROUPS   = 4;
  localparam int unsigned PHASES   = 5;
  localparam int unsigned STEPS    = GROUPS * PHASES;
  localparam int unsigned CNT_W    = $clog2(VALUE_W);

  localparam logic [CODE_W-1:0] CODE_ZERO      = 5'd0;
  localparam logic [CODE_W-1:0] CODE_TEEN_BASE = 5'd10;
  localparam logic [CODE_W-1:0] CODE_TENS_BASE = 5'd18;
  localparam logic [CODE_W-1:0] CODE_HUNDRED   = 5'd28;
  localparam logic [CODE_W-1:0] CODE_THOUSAND  = 5'd29;
  localparam logic [CODE_W-1:0] CODE_MILLION   = 5'd30;
  localparam logic [CODE_W-1:0] CODE_BILLION   = 5'd31;

  // Phases within one group
  localparam logic [2:0] PH_HUND_DIGIT = 3'd0;
  localparam logic [2:0] PH_HUND_WORD  = 3'd1;
  localparam logic [2:0] PH_TENS       = 3'd2;
  localparam logic [2:0] PH_ONES       = 3'd3;
  localparam logic [2:0] PH_SCALE      = 3'd4;

  typedef struct packed {
    logic load;   // capture value, clear converter and step pointer
    logic shift;  // one double-dabble step
    logic step;   // examine one token slot
  } itwt_cmd_t;

  typedef struct packed {
    logic emit_done;  // current slot is the final token, or the last slot
  } itwt_status_t;

endpackage

[sv/itwt_ctrl.sv]
// itwt_ctrl: sequencing FSM for integer_to_word_tokens.
// Depends on itwt_pkg.
module itwt_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  itwt_pkg::itwt_status_t status,
  output itwt_pkg::itwt_cmd_t    cmd,
  output logic                  busy
);
  import itwt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_EMIT
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;

  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(VALUE_W - 1);

  always_comb begin
    state_nxt   = state_r;
    bit_cnt_nxt = bit_cnt_r;
    cmd         = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load    = 1'b1;
          bit_cnt_nxt = '0;
          state_nxt   = S_CONV;
        end
      end
      S_CONV: begin
        cmd.shift   = 1'b1;
        bit_cnt_nxt = bit_cnt_r + 1'b1;
        if (bit_cnt_r == LAST_BIT) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.step = 1'b1;
        if (status.emit_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      bit_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      bit_cnt_r <= bit_cnt_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

[sv/itwt_dp.sv]
// itwt_dp: binary-to-BCD converter, token slot walker and output register
// for integer_to_word_tokens. Depends on itwt_pkg.
module itwt_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  itwt_pkg::itwt_cmd_t               cmd,
  input  logic [itwt_pkg::VALUE_W-1:0]      in_value,
  output itwt_pkg::itwt_status_t            status,
  output logic                              out_valid,
  output logic [itwt_pkg::CODE_W-1:0]       out_word_code,
  output logic                              out_last_word
);
  import itwt_pkg::*;

  logic [VALUE_W-1:0] bin_r;
  logic [BCD_W-1:0]   bcd_r;
  logic [BCD_W-1:0]   bcd_adj;
  logic [STEPS-1:0]   pos_r;    // one-hot current slot
  logic [STEPS-1:0]   rem_r;    // slots after the current one
  logic [1:0]         grp_r;
  logic [2:0]         ph_r;

  logic [3:0]         gh [GROUPS];
  logic [3:0]         gt [GROUPS];
  logic [3:0]         go [GROUPS];
  logic [STEPS-1:0]   emit_vec;
  logic               is_zero;
  logic               cur_emit;
  logic               cur_last;
  logic [CODE_W-1:0]  cur_code;
  logic [3:0]         ch, ct, co;

  logic               out_valid_r;
  logic [CODE_W-1:0]  out_code_r;
  logic               out_last_r;

  // add-3 correction ahead of the shift
  always_comb begin
    for (int k = 0; k < DIGITS; k++) begin
      if (bcd_r[4*k +: 4] >= 4'd5) begin
        bcd_adj[4*k +: 4] = bcd_r[4*k +: 4] + 4'd3;
      end else begin
        bcd_adj[4*k +: 4] = bcd_r[4*k +: 4];
      end
    end
  end

  // group digits: billion group has only its ones digit
  always_comb begin
    for (int g = 1; g < GROUPS; g++) begin
      gh[g] = bcd_r[4*(3*(GROUPS-1-g)+2) +: 4];
      gt[g] = bcd_r[4*(3*(GROUPS-1-g)+1) +: 4];
      go[g] = bcd_r[4*(3*(GROUPS-1-g))   +: 4];
    end
    gh[0] = 4'd0;
    gt[0] = 4'd0;
    go[0] = bcd_r[4*(DIGITS-1) +: 4];
  end

  assign is_zero = (bcd_r == '0);

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      emit_vec[g*PHASES + 0] = (gh[g] != 4'd0);
      emit_vec[g*PHASES + 1] = (gh[g] != 4'd0);
      emit_vec[g*PHASES + 2] = (gt[g] != 4'd0) || (go[g] != 4'd0);
      emit_vec[g*PHASES + 3] = (gt[g] >= 4'd2) && (go[g] != 4'd0);
      emit_vec[g*PHASES + 4] = (g != GROUPS - 1) &&
                               ((gh[g] != 4'd0) || (gt[g] != 4'd0) || (go[g] != 4'd0));
    end
    // the billion group never has a hundreds digit, so its first slot carries Zero
    emit_vec[0] = is_zero;
  end

  assign cur_emit = |(emit_vec & pos_r);
  assign cur_last = ~|(emit_vec & rem_r);

  assign ch = gh[grp_r];
  assign ct = gt[grp_r];
  assign co = go[grp_r];

  always_comb begin
    cur_code = CODE_ZERO;
    unique case (ph_r)
      PH_HUND_DIGIT: cur_code = {1'b0, ch};
      PH_HUND_WORD:  cur_code = CODE_HUNDRED;
      PH_TENS: begin
        if (ct >= 4'd2) begin
          cur_code = CODE_TENS_BASE + {1'b0, ct};
        end else if (ct == 4'd1) begin
          cur_code = CODE_TEEN_BASE + {1'b0, co};
        end else begin
          cur_code = {1'b0, co};
        end
      end
      PH_ONES:       cur_code = {1'b0, co};
      PH_SCALE:      cur_code = CODE_BILLION - {3'b000, grp_r};
      default:       cur_code = CODE_ZERO;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin_r <= in_value;
      bcd_r <= '0;
    end else if (cmd.shift) begin
      bcd_r <= {bcd_adj[BCD_W-2:0], bin_r[VALUE_W-1]};
      bin_r <= {bin_r[VALUE_W-2:0], 1'b0};
    end
    if (cmd.step) begin
      out_code_r <= cur_code;
      out_last_r <= cur_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= STEPS'(1);
      rem_r       <= ~STEPS'(1);
      grp_r       <= '0;
      ph_r        <= PH_HUND_DIGIT;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.step && cur_emit;
      if (cmd.load) begin
        pos_r <= STEPS'(1);
        rem_r <= ~STEPS'(1);
        grp_r <= '0;
        ph_r  <= PH_HUND_DIGIT;
      end else if (cmd.step) begin
        pos_r <= {pos_r[STEPS-2:0], 1'b0};
        rem_r <= {rem_r[STEPS-2:0], 1'b0};
        if (ph_r == PH_SCALE) begin
          ph_r  <= PH_HUND_DIGIT;
          grp_r <= grp_r + 1'b1;
        end else begin
          ph_r <= ph_r + 1'b1;
        end
      end
    end
  end

  assign status.emit_done = (cur_emit && cur_last) || pos_r[STEPS-1];

  assign out_valid     = out_valid_r;
  assign out_word_code = out_code_r;
  assign out_last_word = out_last_r;

endmodule

[sv/integer_to_word_tokens.sv]
// integer_to_word_tokens: spells a 31-bit value as English word tokens.
// After start, the bit-serial BCD converter runs 31 double-dabble steps, then the walker
// examines one token slot per cycle up to and including the last token (1..19 slots).
// A new start is taken only while idle (busy low), so values never overlap.
// Tokens leave on out_valid strobes, at most one per cycle; the receiver cannot stall.
// Synchronous active-low reset returns to idle with no token pending.
module integer_to_word_tokens (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [itwt_pkg::VALUE_W-1:0]  in_value,
  output logic                          out_valid,
  output logic [itwt_pkg::CODE_W-1:0]   out_word_code,
  output logic                          out_last_word
);
  import itwt_pkg::*;

  itwt_cmd_t    cmd;
  itwt_status_t status;

  itwt_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  itwt_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_value      (in_value),
    .status        (status),
    .out_valid     (out_valid),
    .out_word_code (out_word_code),
    .out_last_word (out_last_word)
  );

endmodule
